FILE: sv/buffer_part_stack_with_type_search_defines.svh
// Assertion macros shared by the part stack top level.
// They assume a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef BUFFER_PART_STACK_WITH_TYPE_SEARCH_DEFINES_SVH
`define BUFFER_PART_STACK_WITH_TYPE_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPSTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPSTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bpsts_pkg.sv
`timescale 1ns / 1ps

package bpsts_pkg;

  localparam int unsigned MAX_PARTS = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_PARTS);
  localparam int unsigned CNT_W     = $clog2(MAX_PARTS + 1);
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_TYPE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND_AIM  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND_NEXT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

  // All ones: index -1, "no part".
  localparam logic [INDEX_W-1:0] IDX_NONE = '1;

  // Kind of result loaded into the output register.
  typedef enum logic [2:0] {
    RES_PUSH,
    RES_FULL,
    RES_NO_SPACE,
    RES_POP,
    RES_EMPTY,
    RES_HIT,
    RES_MISS
  } res_e;

  typedef struct packed {
    logic cap_in;
    logic mul;
    logic pop_rd;
    logic scan_step;
    logic load;
    res_e res;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic no_space;
    logic empty;
    logic scan_more;
    logic scan_vld;
    logic hit;
  } dp_sts_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  ptype;
    logic [7:0]  aim;
    logic [31:0] bytes;
  } entry_t;

endpackage

FILE: sv/bpsts_ctrl.sv
`timescale 1ns / 1ps

module bpsts_ctrl
  import bpsts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [MODE_W-1:0] mode_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output dp_cmd_t           cmd_o,
  input  dp_sts_t           sts_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_PUSH   = 3'd2;
  localparam logic [2:0] S_POP_RD = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.res = RES_MISS;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          if (mode_i == MODE_PUSH) begin
            state_d = S_MUL;
          end else if (mode_i == MODE_POP) begin
            state_d = S_POP_RD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          if (sts_i.full) begin
            cmd_o.res = RES_FULL;
          end else if (sts_i.no_space) begin
            cmd_o.res = RES_NO_SPACE;
          end else begin
            cmd_o.res = RES_PUSH;
          end
          state_d = S_IDLE;
        end
      end
      S_POP_RD: begin
        if (sts_i.empty) begin
          if (out_free) begin
            cmd_o.load = 1'b1;
            cmd_o.res  = RES_EMPTY;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d      = S_POP;
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = RES_POP;
          state_d    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_vld && sts_i.hit) begin
          if (out_free) begin
            cmd_o.load = 1'b1;
            cmd_o.res  = RES_HIT;
            state_d    = S_IDLE;
          end
        end else if (!sts_i.scan_vld && !sts_i.scan_more) begin
          if (out_free) begin
            cmd_o.load = 1'b1;
            cmd_o.res  = RES_MISS;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/bpsts_dp.sv
`timescale 1ns / 1ps

module bpsts_dp
  import bpsts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [7:0]           part_type_i,
  input  logic [7:0]           part_aim_i,
  input  logic [15:0]          unit_size_i,
  input  logic [15:0]          unit_count_i,
  input  logic [INDEX_W-1:0]   prev_index_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [INDEX_W-1:0]   index_o,
  output logic [31:0]          part_address_o,
  output logic [31:0]          part_bytes_o,
  output logic [CNT_W-1:0]     part_count_o,
  output logic [31:0]          free_bytes_o
);

  // Allocator state.
  logic [31:0]      base_q, cap_q;
  logic [CNT_W-1:0] used_q, used_d;
  logic [31:0]      fp_q, fp_d;
  logic [31:0]      fs_q, fs_d;

  // Captured item and product.
  logic [MODE_W-1:0]  in_mode_q;
  logic [7:0]         in_type_q, in_aim_q;
  logic [15:0]        in_usize_q, in_ucount_q;
  logic [INDEX_W-1:0] in_prev_q;
  logic [31:0]        prod_q;

  // Part table and its registered read port.
  entry_t           mem [MAX_PARTS];
  entry_t           rd_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;
  entry_t           wr_entry;
  logic [CNT_W-1:0] top_k;

  // Scan cursor.
  logic [CNT_W-1:0] scan_k_q;
  logic             scan_vld_q;
  logic [CNT_W-1:0] scan_start;
  logic             scan_more;

  // Output register next values.
  logic [STATUS_W-1:0] o_status;
  logic [INDEX_W-1:0]  o_index;
  logic [31:0]         o_addr, o_bytes, o_free;
  logic [CNT_W-1:0]    o_count;

  assign top_k     = used_q - CNT_W'(1);
  assign scan_more = scan_k_q < used_q;

  assign sts_o.full      = (used_q == CNT_W'(MAX_PARTS));
  assign sts_o.no_space  = (prod_q > fs_q);
  assign sts_o.empty     = (used_q == '0);
  assign sts_o.scan_more = scan_more;
  assign sts_o.scan_vld  = scan_vld_q;
  assign sts_o.hit       = (rd_q.ptype == in_type_q) &&
                           ((in_mode_q != MODE_FIND_AIM) || (rd_q.aim == in_aim_q));

  // First index a search looks at; an unused mode starts past the end and misses.
  always_comb begin
    unique case (mode_i) inside
      MODE_FIND_TYPE, MODE_FIND_AIM: begin
        scan_start = '0;
      end
      MODE_FIND_NEXT: begin
        if (prev_index_i[INDEX_W-1]) begin
          scan_start = '0;
        end else begin
          scan_start = CNT_W'(prev_index_i[INDEX_W-2:0]) + CNT_W'(1);
        end
      end
      default: begin
        scan_start = CNT_W'(MAX_PARTS);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_mode_q   <= mode_i;
      in_type_q   <= part_type_i;
      in_aim_q    <= part_aim_i;
      in_usize_q  <= unit_size_i;
      in_ucount_q <= unit_count_i;
      in_prev_q   <= prev_index_i;
    end
    if (cmd_i.mul) begin
      prod_q <= 32'(in_usize_q) * 32'(in_ucount_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_k_q   <= '0;
      scan_vld_q <= 1'b0;
    end else if (cmd_i.cap_in) begin
      scan_k_q   <= scan_start;
      scan_vld_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      scan_vld_q <= scan_more;
      if (scan_more) begin
        scan_k_q <= scan_k_q + CNT_W'(1);
      end
    end
  end

  assign rd_addr = cmd_i.pop_rd ? top_k[IDX_W-1:0] : scan_k_q[IDX_W-1:0];
  assign rd_en   = cmd_i.pop_rd || (cmd_i.scan_step && scan_more);
  assign wr_en   = cmd_i.load && (cmd_i.res == RES_PUSH);

  assign wr_entry.addr  = fp_q;
  assign wr_entry.ptype = in_type_q;
  assign wr_entry.aim   = in_aim_q;
  assign wr_entry.bytes = prod_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[used_q[IDX_W-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_comb begin
    o_status = ST_NOT_FOUND;
    o_index  = IDX_NONE;
    o_addr   = '0;
    o_bytes  = '0;
    o_count  = used_q;
    o_free   = fs_q;
    used_d   = used_q;
    fp_d     = fp_q;
    fs_d     = fs_q;
    case (cmd_i.res)
      RES_PUSH: begin
        o_status = ST_OK;
        o_index  = INDEX_W'(used_q[IDX_W-1:0]);
        o_addr   = fp_q;
        o_bytes  = prod_q;
        used_d   = used_q + CNT_W'(1);
        fp_d     = fp_q + prod_q;
        fs_d     = fs_q - prod_q;
        o_count  = used_d;
        o_free   = fs_d;
      end
      RES_FULL: begin
        o_status = ST_FULL;
      end
      RES_NO_SPACE: begin
        o_status = ST_NO_SPACE;
      end
      RES_EMPTY: begin
        o_status = ST_EMPTY;
      end
      RES_POP: begin
        o_status = ST_OK;
        o_index  = INDEX_W'(top_k[IDX_W-1:0]);
        o_addr   = rd_q.addr;
        o_bytes  = rd_q.bytes;
        used_d   = top_k;
        fp_d     = rd_q.addr;
        fs_d     = fs_q + rd_q.bytes;
        o_count  = used_d;
        o_free   = fs_d;
      end
      RES_HIT: begin
        o_status = ST_OK;
        o_index  = INDEX_W'(rd_idx_q);
        o_addr   = rd_q.addr;
        o_bytes  = rd_q.bytes;
      end
      default: begin
        o_status = ST_NOT_FOUND;
        o_index  = (in_mode_q == MODE_FIND_NEXT) ? in_prev_q : IDX_NONE;
      end
    endcase
  end

  // Writing either register restarts the allocator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cap_q  <= '0;
      used_q <= '0;
      fp_q   <= '0;
      fs_q   <= '0;
    end else if (cfg_we_i && (cfg_index_i == CFG_BASE)) begin
      base_q <= cfg_data_i;
      used_q <= '0;
      fp_q   <= cfg_data_i;
      fs_q   <= cap_q;
    end else if (cfg_we_i && (cfg_index_i == CFG_CAPACITY)) begin
      cap_q  <= cfg_data_i;
      used_q <= '0;
      fp_q   <= base_q;
      fs_q   <= cfg_data_i;
    end else if (cmd_i.load) begin
      used_q <= used_d;
      fp_q   <= fp_d;
      fs_q   <= fs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o       <= o_status;
      index_o        <= o_index;
      part_address_o <= o_addr;
      part_bytes_o   <= o_bytes;
      part_count_o   <= o_count;
      free_bytes_o   <= o_free;
    end
  end

endmodule

FILE: sv/buffer_part_stack_with_type_search.sv
// Sequence: a push is captured, its byte size multiplied out and its result then loaded;
// a pop reads the top entry, then loads it, but on an empty table loads from the read step.
// A search scans the table one entry a cycle through the registered read port of the part
// table; every result waits to load while the output register holds an untaken beat.
// Throughput: one item at a time; a new beat is taken as soon as the sequencer is idle again.
// Reset: asynchronous, active low; the table is empty, base and capacity read as zero.
`timescale 1ns / 1ps
`include "buffer_part_stack_with_type_search_defines.svh"

module buffer_part_stack_with_type_search
  import bpsts_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  // Input channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [MODE_W-1:0]           mode_i,
  input  logic [7:0]                  part_type_i,
  input  logic [7:0]                  part_aim_i,
  input  logic [15:0]                 unit_size_i,
  input  logic [15:0]                 unit_count_i,
  input  logic signed [INDEX_W-1:0]   prev_index_i,
  // Output channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [STATUS_W-1:0]         status_o,
  output logic signed [INDEX_W-1:0]   index_o,
  output logic [31:0]                 part_address_o,
  output logic [31:0]                 part_bytes_o,
  output logic [CNT_W-1:0]            part_count_o,
  output logic [31:0]                 free_bytes_o
);

  // The controller steers the datapath through a small command struct and
  // sees only the status flags it needs to choose the next step.
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [INDEX_W-1:0] index_raw;

  // Always taken unchecked; the user must issue register writes only while the block is idle.
  assign cfg_ready_o = 1'b1;
  assign index_o     = index_raw;

  bpsts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the part table, the allocator registers and the
  // output register, so a finished result can wait there while the next
  // input beat is already being taken.
  bpsts_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .part_type_i    (part_type_i),
    .part_aim_i     (part_aim_i),
    .unit_size_i    (unit_size_i),
    .unit_count_i   (unit_count_i),
    .prev_index_i   (prev_index_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .index_o        (index_raw),
    .part_address_o (part_address_o),
    .part_bytes_o   (part_bytes_o),
    .part_count_o   (part_count_o),
    .free_bytes_o   (free_bytes_o)
  );

  // Once a beat is taken, the sequencer is busy in the following cycle.
  `BPSTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")

  // The part count reported can never exceed the table depth.
  `BPSTS_ASSERT_NOW(a_count_bound, out_valid_o, part_count_o <= CNT_W'(MAX_PARTS), "count overflow")

  // A refused push or pop names no part: address and size zero, index -1.
  `BPSTS_ASSERT_NOW(a_refused_clean, out_valid_o && (status_o == ST_FULL || status_o == ST_EMPTY || status_o == ST_NO_SPACE), part_address_o == '0 && part_bytes_o == '0 && index_o == IDX_NONE, "refused result not clean")

endmodule

FILE: verif/buffer_part_stack_with_type_search_test.sv
`timescale 1ns / 1ps

module buffer_part_stack_with_type_search_test;
  import bpsts_pkg::*;

  // The run is stopped here if the traffic has not drained by then. This is several times the
  // slowest correct run: every beat waiting out the longest sender gap, the longest search and
  // the longest receiver stall.
  localparam int unsigned RUN_LIMIT_NS = 1_200_000;
  // Cycles allowed after the last expected result before the final verdict.
  localparam int unsigned TAIL_CYCLES = 24;
  // Register index outside the list; a write to it must leave the allocator alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
  // Beyond this many mismatches the report lines are suppressed, but still counted.
  localparam int unsigned REPORT_CAP = 40;

  // One request as offered on the input channel.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [7:0]         ptype;
    logic [7:0]         aim;
    logic [15:0]        unit_size;
    logic [15:0]        unit_count;
    logic [INDEX_W-1:0] prev;
  } part_request_t;

  // One result as it should appear on the output channel.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index_bits;
    logic [31:0]         address;
    logic [31:0]         size_bytes;
    logic [CNT_W-1:0]    parts;
    logic [31:0]         free_bytes;
  } part_answer_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [31:0]               cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [MODE_W-1:0]         mode_i = '0;
  logic [7:0]                part_type_i = '0;
  logic [7:0]                part_aim_i = '0;
  logic [15:0]               unit_size_i = '0;
  logic [15:0]               unit_count_i = '0;
  logic signed [INDEX_W-1:0] prev_index_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [STATUS_W-1:0]       status_o;
  logic signed [INDEX_W-1:0] index_o;
  logic [31:0]               part_address_o;
  logic [31:0]               part_bytes_o;
  logic [CNT_W-1:0]          part_count_o;
  logic [31:0]               free_bytes_o;

  // Shadow of the allocator: the part table, the stack pointers and the two registers.
  entry_t       part_table [MAX_PARTS];
  int           parts_used = 0;
  logic [31:0]  next_free = '0;
  logic [31:0]  space_left = '0;
  logic [31:0]  buffer_base = '0;
  logic [31:0]  buffer_room = '0;

  // Results predicted at input acceptance, oldest first.
  part_answer_t expected_answers[$];
  int unsigned  mismatches = 0;
  // Remaining beats of a stretch without idling, one counter for each side.
  int           in_quiet = 0;
  int           out_quiet = 0;

  buffer_part_stack_with_type_search DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .part_type_i    (part_type_i),
    .part_aim_i     (part_aim_i),
    .unit_size_i    (unit_size_i),
    .unit_count_i   (unit_count_i),
    .prev_index_i   (prev_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .index_o        (index_o),
    .part_address_o (part_address_o),
    .part_bytes_o   (part_bytes_o),
    .part_count_o   (part_count_o),
    .free_bytes_o   (free_bytes_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin : run_limit
    #RUN_LIMIT_NS;
    $display("buffer_part_stack_with_type_search: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < REPORT_CAP) begin
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Idle cycles before the next beat on one side. Now and then a stretch of back-to-back
  // beats is started so that the block also sees full-rate traffic.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // A write to either register restarts the allocator; a write to a spare index does nothing.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [31:0] data);
    case (idx)
      CFG_BASE:     buffer_base = data;
      CFG_CAPACITY: buffer_room = data;
      default:      return;
    endcase
    foreach (part_table[k]) part_table[k] = '0;
    parts_used = 0;
    next_free  = buffer_base;
    space_left = buffer_room;
  endfunction

  function automatic part_answer_t hit_answer(input int k);
    part_answer_t ans;
    ans            = '0;
    ans.status     = ST_OK;
    ans.index_bits = INDEX_W'(k);
    ans.address    = part_table[k].addr;
    ans.size_bytes = part_table[k].bytes;
    return ans;
  endfunction

  // Applies one request to the shadow allocator and returns the result it should give.
  function automatic part_answer_t predict_answer(input part_request_t req);
    part_answer_t ans;
    logic [31:0]  need;
    int           first;
    int           k;
    logic         hit;
    ans            = '0;
    ans.status     = ST_NOT_FOUND;
    ans.index_bits = IDX_NONE;
    hit            = 1'b0;
    case (req.mode)
      MODE_PUSH: begin
        need = {16'd0, req.unit_size} * {16'd0, req.unit_count};
        if (parts_used >= MAX_PARTS) begin
          ans.status = ST_FULL;
        end else if (need > space_left) begin
          ans.status = ST_NO_SPACE;
        end else begin
          part_table[parts_used] = '{addr: next_free, ptype: req.ptype, aim: req.aim,
                                     bytes: need};
          ans = hit_answer(parts_used);
          parts_used++;
          space_left -= need;
          // The free pointer simply wraps round the 32-bit address space.
          next_free += need;
        end
      end
      MODE_POP: begin
        if (parts_used == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          k = parts_used - 1;
          ans = hit_answer(k);
          space_left += part_table[k].bytes;
          next_free = part_table[k].addr;
          // The whole entry goes, its aim included.
          part_table[k] = '0;
          parts_used = k;
        end
      end
      MODE_FIND_TYPE, MODE_FIND_AIM: begin
        for (k = 0; k < parts_used; k++) begin
          if (!hit && part_table[k].ptype == req.ptype &&
              (req.mode != MODE_FIND_AIM || part_table[k].aim == req.aim)) begin
            ans = hit_answer(k);
            hit = 1'b1;
          end
        end
      end
      MODE_FIND_NEXT: begin
        // Any negative start index searches from the bottom of the table; a failed search
        // hands the start index back.
        first = req.prev[INDEX_W-1] ? 0 : int'(req.prev) + 1;
        ans.index_bits = req.prev;
        for (k = first; k < parts_used; k++) begin
          if (!hit && part_table[k].ptype == req.ptype) begin
            ans = hit_answer(k);
            hit = 1'b1;
          end
        end
      end
      default: begin
        // Unused modes leave everything alone and report a miss.
      end
    endcase
    ans.parts      = CNT_W'(parts_used);
    ans.free_bytes = space_left;
    return ans;
  endfunction

  // Offers one beat on the input channel and records its prediction when it is taken.
  // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
  task automatic send_part(input logic [MODE_W-1:0] mode, input logic [7:0] ptype,
                           input logic [7:0] aim, input logic [15:0] usize,
                           input logic [15:0] ucount, input logic [INDEX_W-1:0] prev);
    part_request_t item;
    int            gap;
    item = '{mode: mode, ptype: ptype, aim: aim, unit_size: usize, unit_count: ucount,
             prev: prev};
    gap  = draw_gap(in_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    part_type_i  <= ptype;
    part_aim_i   <= aim;
    unit_size_i  <= usize;
    unit_count_i <= ucount;
    prev_index_i <= prev;
    do @(posedge clk_i); while (!in_ready_o);
    expected_answers.push_back(predict_answer(item));
  endtask

  // Stops the input channel and waits until every predicted result has been seen.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_register(idx, data);
  endtask

  // Out of reset the buffer has no room at all, so only a part of zero bytes fits.
  task automatic test_reset_state();
    send_part(MODE_POP, 8'h00, 8'h00, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_PUSH, 8'h00, 8'h00, 16'd0, 16'hFFFF, IDX_NONE);
    send_part(MODE_PUSH, 8'h01, 8'h01, 16'd1, 16'd1, IDX_NONE);
    send_part(MODE_FIND_TYPE, 8'h00, 8'h00, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_POP, 8'h00, 8'h00, 16'd0, 16'd0, IDX_NONE);
  endtask

  task automatic test_push_pop_search();
    write_register(CFG_BASE, 32'h0000_1000);
    write_register(CFG_CAPACITY, 32'h0000_0100);
    // Searches on an empty table, then the unused modes.
    send_part(MODE_FIND_TYPE, 8'hFF, 8'h00, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_FIND_NEXT, 8'h5A, 8'h00, 16'd0, 16'd0, IDX_NONE);
    for (int m = 1; m <= 3; m++) begin
      send_part(MODE_FIND_NEXT + MODE_W'(m), 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, IDX_NONE);
    end
    // Fill the buffer exactly, with a push far too large in between.
    send_part(MODE_PUSH, 8'hFF, 8'h00, 16'h0010, 16'h0004, IDX_NONE);
    send_part(MODE_PUSH, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, IDX_NONE);
    send_part(MODE_PUSH, 8'h00, 8'hFF, 16'h0003, 16'h0040, IDX_NONE);
    send_part(MODE_PUSH, 8'hAA, 8'h55, 16'h0000, 16'h0000, IDX_NONE);
    send_part(MODE_FIND_TYPE, 8'hAA, 8'h00, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_FIND_AIM, 8'h00, 8'hFF, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_FIND_AIM, 8'h00, 8'h00, 16'd0, 16'd0, IDX_NONE);
    // Find next from far below minus one, from the only match, and from past the end.
    send_part(MODE_FIND_NEXT, 8'hFF, 8'h00, 16'd0, 16'd0, 5'b10000);
    send_part(MODE_FIND_NEXT, 8'hFF, 8'h00, 16'd0, 16'd0, 5'b00000);
    send_part(MODE_FIND_NEXT, 8'hAA, 8'h00, 16'd0, 16'd0, 5'b01111);
    // A popped entry must lose its aim: the old pair may no longer be found.
    send_part(MODE_POP, 8'h00, 8'h00, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_PUSH, 8'hAA, 8'h77, 16'h0000, 16'h0001, IDX_NONE);
    send_part(MODE_FIND_AIM, 8'hAA, 8'h55, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_FIND_AIM, 8'hAA, 8'h77, 16'd0, 16'd0, IDX_NONE);
  endtask

  // A buffer near the top of the address space makes the free pointer wrap round past zero.
  task automatic test_pointer_wrap();
    write_register(CFG_BASE, 32'hFFFF_FF00);
    write_register(CFG_CAPACITY, 32'hFFFF_FFFF);
    send_part(MODE_PUSH, 8'h12, 8'h34, 16'h0100, 16'h0002, IDX_NONE);
    send_part(MODE_PUSH, 8'h12, 8'h35, 16'h0001, 16'h0001, IDX_NONE);
    send_part(MODE_POP, 8'h00, 8'h00, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_POP, 8'h00, 8'h00, 16'd0, 16'd0, IDX_NONE);
  endtask

  // Sixteen parts fill the table; the next push must be refused without touching the space.
  task automatic test_full_table();
    write_register(CFG_CAPACITY, 32'h0001_0000);
    for (int k = 0; k <= MAX_PARTS; k++) begin
      send_part(MODE_PUSH, 8'(k % 4), 8'(k), 16'(k), 16'h0003, IDX_NONE);
    end
    send_part(MODE_FIND_NEXT, 8'd3, 8'h00, 16'd0, 16'd0, 5'd14);
    send_part(MODE_FIND_AIM, 8'd3, 8'd15, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_POP, 8'h00, 8'h00, 16'd0, 16'd0, IDX_NONE);
    send_part(MODE_PUSH, 8'h00, 8'h00, 16'h0001, 16'h0001, IDX_NONE);
  endtask

  // Mostly small types and sizes, so that searches hit and pushes usually fit; now and then
  // the full range of every field.
  task automatic send_random_part(input int push_share, input int pop_share);
    logic [MODE_W-1:0] mode;
    logic [7:0]        ptype;
    logic [7:0]        aim;
    logic [15:0]       usize;
    logic [15:0]       ucount;
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < push_share) begin
      mode = MODE_PUSH;
    end else if (roll < push_share + pop_share) begin
      mode = MODE_POP;
    end else if (roll < push_share + pop_share + 10) begin
      mode = MODE_FIND_TYPE;
    end else if (roll < push_share + pop_share + 20) begin
      mode = MODE_FIND_AIM;
    end else if (roll < 97) begin
      mode = MODE_FIND_NEXT;
    end else begin
      mode = MODE_FIND_NEXT + MODE_W'($urandom_range(1, 3));
    end
    ptype = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
    aim   = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 2));
    case ($urandom_range(0, 15))
      0: begin
        usize  = 16'($urandom());
        ucount = 16'($urandom());
      end
      1: begin
        usize  = '0;
        ucount = 16'($urandom());
      end
      2: begin
        usize  = 16'($urandom());
        ucount = '0;
      end
      default: begin
        usize  = 16'($urandom_range(1, 64));
        ucount = 16'($urandom_range(1, 64));
      end
    endcase
    send_part(mode, ptype, aim, usize, ucount, INDEX_W'($urandom()));
  endtask

  // Phases with different buffers, including the extremes of both registers, and with the
  // balance of pushes against pops alternating so that the table both fills and empties.
  task automatic test_random_traffic();
    logic [31:0] base;
    logic [31:0] room;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 6)
        0:       room = $urandom_range(256, 4096);
        1:       room = $urandom_range(4096, 200000);
        2:       room = 32'hFFFF_FFFF;
        3:       room = '0;
        4:       room = $urandom_range(0, 1024);
        default: room = $urandom();
      endcase
      case (phase % 6)
        2:       base = 32'hFFFF_FFFF;
        3:       base = '0;
        default: base = $urandom();
      endcase
      if (phase % 3 != 1) begin
        write_register(CFG_BASE, base);
      end
      write_register(CFG_CAPACITY, room);
      for (int n = 0; n < 150; n++) begin
        if (phase == 5 && n == 75) begin
          write_register(CFG_SPARE, $urandom());
        end
        if (phase % 2 == 0) begin
          send_random_part(45, 15);
        end else begin
          send_random_part(25, 30);
        end
      end
    end
  endtask

  // Result side: stalls at random before each beat, then checks the beat field by field
  // against the oldest prediction.
  initial begin : result_check
    part_answer_t want;
    int           stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(out_quiet);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (expected_answers.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(status_o), '0);
      end else begin
        want = expected_answers.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (index_o !== want.index_bits) begin
          report_mismatch("index", 32'(index_o), 32'(want.index_bits));
        end
        if (part_address_o !== want.address) begin
          report_mismatch("part address", part_address_o, want.address);
        end
        if (part_bytes_o !== want.size_bytes) begin
          report_mismatch("part bytes", part_bytes_o, want.size_bytes);
        end
        if (part_count_o !== want.parts) begin
          report_mismatch("part count", 32'(part_count_o), 32'(want.parts));
        end
        if (free_bytes_o !== want.free_bytes) begin
          report_mismatch("free bytes", free_bytes_o, want.free_bytes);
        end
      end
    end
  end

  initial begin : main_sequence
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_push_pop_search();
    test_pointer_wrap();
    test_full_table();
    test_random_traffic();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_answers.size() != 0) begin
      report_mismatch("results never delivered", expected_answers.size(), '0);
    end
    if (mismatches == 0) begin
      $display("buffer_part_stack_with_type_search: match");
    end else begin
      $display("buffer_part_stack_with_type_search: mismatch");
    end
    $finish;
  end

endmodule
